>>> hdl/tmcm_pkg.sv
`default_nettype none

package tmcm_pkg;

    // sample and field widths
    localparam int SAMPLE_BITS    = 12;
    localparam int SCREEN_X_BITS  = 9;
    localparam int SCREEN_Y_BITS  = 8;
    localparam int CFG_INDEX_BITS = 8;
    localparam int IN_DATA_BITS   = 112;
    localparam int OUT_DATA_BITS  = 56;
    localparam int OUT_USER_BITS  = 2;

    // default landscape geometry
    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_AT_ZERO          = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_AT_FULL          = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_AT_ZERO          = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_AT_FULL          = 8'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PRESSURE_THRESHOLD = 8'd4;

    // register reset values
    localparam logic [SAMPLE_BITS-1:0] X_AT_ZERO_RST          = 12'd300;
    localparam logic [SAMPLE_BITS-1:0] X_AT_FULL_RST          = 12'd3800;
    localparam logic [SAMPLE_BITS-1:0] Y_AT_ZERO_RST          = 12'd300;
    localparam logic [SAMPLE_BITS-1:0] Y_AT_FULL_RST          = 12'd3800;
    localparam logic [SAMPLE_BITS-1:0] PRESSURE_THRESHOLD_RST = 12'd400;

    // how an axis resolves
    localparam logic [1:0] MAP_ZERO = 2'd0;
    localparam logic [1:0] MAP_FULL = 2'd1;
    localparam logic [1:0] MAP_DIV  = 2'd2;

    typedef struct packed {
        logic [1:0]             kind;
        logic [SAMPLE_BITS-1:0] diff;
        logic [SAMPLE_BITS-1:0] span;
    } axis_t;

    typedef struct packed {
        logic                   contact;
        logic                   pressed;
        logic [SAMPLE_BITS-1:0] med_x;
        logic [SAMPLE_BITS-1:0] med_y;
        logic [SAMPLE_BITS-1:0] med_z;
    } side_t;

    typedef struct packed {
        side_t side;
        axis_t col;   // screen column, from raw y
        axis_t row;   // screen row, from raw x
    } item_t;

endpackage

`default_nettype wire

>>> hdl/touch_median_calibrate_map_unit.sv
`default_nettype none

// Resistive touch filter and calibrated mapper. Each transfer on the input stream carries the
// pen-contact flag and three conversions each of pressure, X and Y; the block takes the median
// of each triple (reported as 0 without contact), decides pressed when there is contact and the
// median pressure is strictly above pressure_threshold, and maps median Y to the landscape column
// and median X to the inverted landscape row, clamped at the calibration points (a reversed
// axis, lo above hi, is fine; equal points map that axis to 0 before inversion). Coordinates
// read 0 when not pressed. Its only configuration state is the five calibration registers,
// written through the cfg channel (index 0..4, anything above is ignored; cfg_ready is always
// high); the user must write them only while no transfer is in flight, which the block does
// not enforce. One item is accepted per clock cycle with the output side ready; the two
// pipelined restoring dividers give one quotient bit per stage, clog2(max(SCREEN_WIDTH,
// SCREEN_HEIGHT)) stages (9 at 320x240). An item passes the queue, the scaling stage, the
// divider stages and the output register, all held while the output stalls. A two-entry
// queue between classifying front and dividing back takes inputs until full while a result waits.

module touch_median_calibrate_map_unit #(
    parameter int SCREEN_WIDTH  = tmcm_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tmcm_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    // input stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // z_first, z_second, z_third, x_first, x_second, x_third, y_first, y_second, y_third,
    // 12 bits each from bit 0, then zero fill
    input  wire logic [tmcm_pkg::IN_DATA_BITS-1:0]     s_tdata,
    // contact
    input  wire logic                                  s_tuser,

    // result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // screen_x (9), screen_y (8), median_x (12), median_y (12), median_z (12), then zero fill
    output logic [tmcm_pkg::OUT_DATA_BITS-1:0]         m_tdata,
    // contact_seen, pressed
    output logic [tmcm_pkg::OUT_USER_BITS-1:0]         m_tuser,

    // calibration register writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tmcm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [tmcm_pkg::SAMPLE_BITS-1:0]      cfg_data
);

    tmcm_pkg::item_t front_item;
    tmcm_pkg::item_t queue_item;
    logic            queue_valid;
    logic            queue_pop;

    // front: calibration registers, medians and per-axis classification
    tmcm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .item      (front_item)
    );

    // short queue, input transfer is taken whenever it has room
    tmcm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_item  (front_item),
        .rd_valid (queue_valid),
        .rd_pop   (queue_pop),
        .rd_item  (queue_item)
    );

    // back: scale, divide, invert and register the result
    tmcm_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (queue_valid),
        .q_pop    (queue_pop),
        .q_item   (queue_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> hdl/tmcm_front.sv
`default_nettype none

module tmcm_front (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [tmcm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [tmcm_pkg::SAMPLE_BITS-1:0]       cfg_data,
    input  wire logic                                   s_tuser,
    input  wire logic [tmcm_pkg::IN_DATA_BITS-1:0]      s_tdata,
    output tmcm_pkg::item_t                             item
);

    localparam int S = tmcm_pkg::SAMPLE_BITS;

    logic [S-1:0] x_zero_reg;
    logic [S-1:0] x_full_reg;
    logic [S-1:0] y_zero_reg;
    logic [S-1:0] y_full_reg;
    logic [S-1:0] thr_reg;

    logic [S-1:0] med_x;
    logic [S-1:0] med_y;
    logic [S-1:0] med_z;
    logic         pressed;

    function automatic logic [S-1:0] median3(input logic [S-1:0] a, input logic [S-1:0] b,
                                              input logic [S-1:0] c);
        logic [S-1:0] lo;
        logic [S-1:0] hi;
        logic [S-1:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    // normal and reversed axes; equal points resolve to zero
    function automatic tmcm_pkg::axis_t classify(input logic [S-1:0] raw,
                                                 input logic [S-1:0] lo,
                                                 input logic [S-1:0] hi);
        tmcm_pkg::axis_t a;
        a.kind = tmcm_pkg::MAP_ZERO;
        a.diff = raw - lo;
        a.span = hi - lo;
        if (lo < hi)
        begin
            if (raw <= lo)
                a.kind = tmcm_pkg::MAP_ZERO;
            else if (raw >= hi)
                a.kind = tmcm_pkg::MAP_FULL;
            else
                a.kind = tmcm_pkg::MAP_DIV;
        end
        else if (lo > hi)
        begin
            a.diff = lo - raw;
            a.span = lo - hi;
            if (raw >= lo)
                a.kind = tmcm_pkg::MAP_ZERO;
            else if (raw <= hi)
                a.kind = tmcm_pkg::MAP_FULL;
            else
                a.kind = tmcm_pkg::MAP_DIV;
        end
        return a;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_zero_reg <= tmcm_pkg::X_AT_ZERO_RST;
            x_full_reg <= tmcm_pkg::X_AT_FULL_RST;
            y_zero_reg <= tmcm_pkg::Y_AT_ZERO_RST;
            y_full_reg <= tmcm_pkg::Y_AT_FULL_RST;
            thr_reg    <= tmcm_pkg::PRESSURE_THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tmcm_pkg::REG_X_AT_ZERO:          x_zero_reg <= cfg_data;
                tmcm_pkg::REG_X_AT_FULL:          x_full_reg <= cfg_data;
                tmcm_pkg::REG_Y_AT_ZERO:          y_zero_reg <= cfg_data;
                tmcm_pkg::REG_Y_AT_FULL:          y_full_reg <= cfg_data;
                tmcm_pkg::REG_PRESSURE_THRESHOLD: thr_reg    <= cfg_data;
                default:                          ;
            endcase
        end
    end

    always_comb
    begin
        med_z = '0;
        med_x = '0;
        med_y = '0;
        if (s_tuser)
        begin
            med_z = median3(s_tdata[S-1:0], s_tdata[2*S-1:S], s_tdata[3*S-1:2*S]);
            med_x = median3(s_tdata[4*S-1:3*S], s_tdata[5*S-1:4*S], s_tdata[6*S-1:5*S]);
            med_y = median3(s_tdata[7*S-1:6*S], s_tdata[8*S-1:7*S], s_tdata[9*S-1:8*S]);
        end
        pressed = s_tuser && (med_z > thr_reg);

        item.side.contact = s_tuser;
        item.side.pressed = pressed;
        item.side.med_x   = med_x;
        item.side.med_y   = med_y;
        item.side.med_z   = med_z;
        item.col          = classify(med_y, y_zero_reg, y_full_reg);
        item.row          = classify(med_x, x_zero_reg, x_full_reg);
    end

endmodule

`default_nettype wire

>>> hdl/tmcm_queue.sv
`default_nettype none

module tmcm_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_valid,
    output logic                 wr_ready,
    input  wire tmcm_pkg::item_t wr_item,
    output logic                 rd_valid,
    input  wire logic            rd_pop,
    output tmcm_pkg::item_t      rd_item
);

    localparam int DEPTH    = tmcm_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    tmcm_pkg::item_t       entry_reg [0:DEPTH-1];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [CNT_BITS-1:0]   count_next;
    logic                  push;
    logic                  pop;

    assign wr_ready = (count_reg != CNT_BITS'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;
    assign rd_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

`default_nettype wire

>>> hdl/tmcm_div.sv
`default_nettype none

module tmcm_div #(
    parameter int TOP   = tmcm_pkg::SCREEN_WIDTH_DEF - 1,
    parameter int STEPS = 9
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic [1:0]                        kind,
    input  wire logic [tmcm_pkg::SAMPLE_BITS-1:0]  diff,
    input  wire logic [tmcm_pkg::SAMPLE_BITS-1:0]  span,
    output logic      [tmcm_pkg::SAMPLE_BITS-1:0]  result
);

    localparam int S  = tmcm_pkg::SAMPLE_BITS;
    localparam int PW = 2 * S;
    localparam logic [S-1:0] TOP_VAL = S'(TOP);

    logic [PW-1:0]    rem_reg  [0:STEPS];
    logic [STEPS-1:0] quo_reg  [0:STEPS];
    logic [S-1:0]     span_reg [0:STEPS];
    logic [1:0]       kind_reg [0:STEPS];

    logic [PW:0]      trial [0:STEPS-1];
    logic [STEPS-1:0] take;

    // restoring division, one quotient bit per stage, msb first
    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            trial[k] = {1'b0, rem_reg[k]} - ((PW + 1)'(span_reg[k]) << (STEPS - 1 - k));
            take[k]  = !trial[k][PW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= PW'(diff) * PW'(TOP_VAL);
            quo_reg[0]  <= '0;
            span_reg[0] <= span;
            kind_reg[0] <= kind;
            for (int k = 0; k < STEPS; k++)
            begin
                rem_reg[k+1]  <= take[k] ? trial[k][PW-1:0] : rem_reg[k];
                quo_reg[k+1]  <= STEPS'({quo_reg[k], take[k]});
                span_reg[k+1] <= span_reg[k];
                kind_reg[k+1] <= kind_reg[k];
            end
        end
    end

    always_comb
    begin
        case (kind_reg[STEPS])
            tmcm_pkg::MAP_DIV:  result = S'(quo_reg[STEPS]);
            tmcm_pkg::MAP_FULL: result = TOP_VAL;
            default:            result = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/tmcm_back.sv
`default_nettype none

module tmcm_back #(
    parameter int SCREEN_WIDTH  = tmcm_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tmcm_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  q_valid,
    output logic                                       q_pop,
    input  wire tmcm_pkg::item_t                       q_item,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [tmcm_pkg::OUT_DATA_BITS-1:0]         m_tdata,
    output logic [tmcm_pkg::OUT_USER_BITS-1:0]         m_tuser
);

    localparam int S  = tmcm_pkg::SAMPLE_BITS;
    localparam int XB = tmcm_pkg::SCREEN_X_BITS;
    localparam int YB = tmcm_pkg::SCREEN_Y_BITS;
    localparam int DIV_STEPS =
        $clog2((SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT);
    localparam logic [S-1:0] ROW_TOP = S'(SCREEN_HEIGHT - 1);
    localparam int PAD_BITS = tmcm_pkg::OUT_DATA_BITS - XB - YB - 3 * S;

    logic                 en;
    logic [DIV_STEPS:0]   vld_reg;
    tmcm_pkg::side_t      side_reg [0:DIV_STEPS];
    logic [S-1:0]         col_map;
    logic [S-1:0]         row_map;
    logic [S-1:0]         row_scr;

    logic                 m_tvalid_reg;
    logic                 contact_reg;
    logic                 pressed_reg;
    logic [XB-1:0]        sx_reg;
    logic [YB-1:0]        sy_reg;
    logic [S-1:0]         mx_reg;
    logic [S-1:0]         my_reg;
    logic [S-1:0]         mz_reg;

    // whole pipeline advances while the output register is free or being drained
    assign en    = !m_tvalid_reg || m_tready;
    assign q_pop = en && q_valid;

    tmcm_div #(
        .TOP   (SCREEN_WIDTH - 1),
        .STEPS (DIV_STEPS)
    ) u_col_div (
        .clk    (clk),
        .en     (en),
        .kind   (q_item.col.kind),
        .diff   (q_item.col.diff),
        .span   (q_item.col.span),
        .result (col_map)
    );

    tmcm_div #(
        .TOP   (SCREEN_HEIGHT - 1),
        .STEPS (DIV_STEPS)
    ) u_row_div (
        .clk    (clk),
        .en     (en),
        .kind   (q_item.row.kind),
        .diff   (q_item.row.diff),
        .span   (q_item.row.span),
        .result (row_map)
    );

    // screen row runs opposite to raw x
    assign row_scr = ROW_TOP - row_map;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg      <= (DIV_STEPS + 1)'({vld_reg, q_valid});
            m_tvalid_reg <= vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= q_item.side;
            for (int k = 1; k <= DIV_STEPS; k++)
                side_reg[k] <= side_reg[k-1];
            contact_reg <= side_reg[DIV_STEPS].contact;
            pressed_reg <= side_reg[DIV_STEPS].pressed;
            sx_reg      <= side_reg[DIV_STEPS].pressed ? col_map[XB-1:0] : '0;
            sy_reg      <= side_reg[DIV_STEPS].pressed ? row_scr[YB-1:0] : '0;
            mx_reg      <= side_reg[DIV_STEPS].med_x;
            my_reg      <= side_reg[DIV_STEPS].med_y;
            mz_reg      <= side_reg[DIV_STEPS].med_z;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {pressed_reg, contact_reg};
    assign m_tdata  = {{PAD_BITS{1'b0}}, mz_reg, my_reg, mx_reg, sy_reg, sx_reg};

`ifndef ASSERT_OFF
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_last_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[DIV_STEPS] |=> m_tvalid_reg)
        else $error("finished item did not reach the output register");

    a_no_contact_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !contact_reg |->
            !pressed_reg && mx_reg == '0 && my_reg == '0 && mz_reg == '0)
        else $error("result without contact carries medians or press");

    a_release_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !pressed_reg |-> sx_reg == '0 && sy_reg == '0)
        else $error("coordinates reported while not pressed");
`endif

endmodule

`default_nettype wire
